### hw/rtl/ssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spin state classifier package
// Word types, configuration register indexes and fixed widths shared by the
// classifier and its filter.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MagW     = 15;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned AlphaW   = 9;
  localparam int unsigned DebW     = 4;

  localparam logic [AlphaW-1:0] AlphaMin = 9'd3;
  localparam logic [AlphaW-1:0] AlphaMax = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_USE_MANUAL = 3'd0,
    CFG_MANUAL     = 3'd1,
    CFG_ENTER      = 3'd2,
    CFG_EXIT       = 3'd3,
    CFG_ALPHA      = 3'd4,
    CFG_STATIC     = 3'd5
  } ssc_cfg_idx_e;

  typedef struct packed {
    logic signed [SpeedW-1:0] observed_speed;
    logic                     is_outpost;
    logic                     plate_jumped;
    logic [2:0]               plate_count;
  } ssc_in_t;

  typedef struct packed {
    logic                     updated;
    logic                     spinning;
    logic                     outpost_still;
    logic [MagW-1:0]          filtered_magnitude;
    logic signed [SpeedW-1:0] effective_speed;
  } ssc_out_t;

endpackage
`default_nettype wire

### hw/rtl/ssc_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spin state classifier low-pass filter
// First-order update of the speed magnitude, loaded directly by the first
// sample, computed as value + alpha * (mag - value) / 256, rounded down.
// ----------------------------------------------------------------------------
module ssc_filter
  import ssc_pkg::*;
(
  input  wire logic [MagW-1:0]   mag_i,
  input  wire logic [MagW-1:0]   value_i,
  input  wire logic              loaded_i,
  input  wire logic [AlphaW-1:0] alpha_i,
  output logic      [MagW-1:0]   value_o
);

  logic [AlphaW-1:0]                alpha_c;
  logic signed [MagW:0]             diff;
  logic signed [AlphaW+MagW+1:0]    prod;
  logic signed [AlphaW+MagW+1:0]    step;
  logic signed [AlphaW+MagW+1:0]    sum;

  always_comb begin
    if (alpha_i < AlphaMin) begin
      alpha_c = AlphaMin;
    end else if (alpha_i > AlphaMax) begin
      alpha_c = AlphaMax;
    end else begin
      alpha_c = alpha_i;
    end
    diff = $signed({1'b0, mag_i}) - $signed({1'b0, value_i});
    prod = $signed({1'b0, alpha_c}) * diff;
    step = prod >>> 8;
    sum  = $signed({{(AlphaW+2){1'b0}}, value_i}) + step;
    if (loaded_i) begin
      value_o = sum[MagW-1:0];
    end else begin
      value_o = mag_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/spin_state_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spin state classifier
// Low-pass filtered speed magnitude with hysteresis spin detection and a
// debounced still/rotating decision for outpost targets.
// ----------------------------------------------------------------------------
// The block accepts one input word per clock while in_stall_o is low and
// returns one result word for each, held first in the input register and
// then in the result register. The combinational filter update (one 10 by
// 16 bit multiply and add) also updates the classifier state. Configuration
// registers should be written only while no word is in flight.
module spin_state_classifier
  import ssc_pkg::*;
#(
  parameter int unsigned STILL_ENTER_COUNT  = 15,
  parameter int unsigned STILL_EXIT_COUNT   = 5,
  parameter int unsigned OUTPOST_SPIN_SPEED = 640
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ssc_in_t             in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ssc_out_t                 out_word_o
);

  localparam logic [DebW-1:0]   EnterCnt = DebW'(STILL_ENTER_COUNT);
  localparam logic [DebW-1:0]   ExitCnt  = DebW'(STILL_EXIT_COUNT);
  localparam logic [MagW-1:0]   SpinMag  = MagW'(OUTPOST_SPIN_SPEED);
  localparam logic [SpeedW-1:0] SpinPos  = SpeedW'(OUTPOST_SPIN_SPEED);

  logic              use_manual_q;
  logic [SpeedW-1:0] manual_q;
  logic [MagW-1:0]   enter_q;
  logic [MagW-1:0]   exit_q;
  logic [AlphaW-1:0] alpha_q;
  logic [MagW-1:0]   static_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_manual_q <= 1'b0;
      manual_q     <= 16'd640;
      enter_q      <= 15'd614;
      exit_q       <= 15'd461;
      alpha_q      <= 9'd64;
      static_q     <= 15'd38;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_USE_MANUAL: use_manual_q <= cfg_wdata_i[0];
        CFG_MANUAL:     manual_q     <= cfg_wdata_i;
        CFG_ENTER:      enter_q      <= cfg_wdata_i[MagW-1:0];
        CFG_EXIT:       exit_q       <= cfg_wdata_i[MagW-1:0];
        CFG_ALPHA:      alpha_q      <= cfg_wdata_i[AlphaW-1:0];
        CFG_STATIC:     static_q     <= cfg_wdata_i[MagW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the input register and the result register.
  logic    in_valid_q;
  ssc_in_t in_word_q;
  logic    out_advance;
  logic    move;
  logic    accept;

  assign out_advance = !out_valid_o || !out_stall_i;
  assign move        = in_valid_q && out_advance;
  assign in_stall_o  = in_valid_q && !out_advance;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
  end

  // Classifier state.
  logic            loaded_q, loaded_d;
  logic [MagW-1:0] filt_q, filt_d;
  logic            spin_q, spin_d;
  logic            still_q, still_d;
  logic [DebW-1:0] deb_q, deb_d;

  logic [SpeedW-1:0] speed;
  logic [SpeedW-1:0] abs16;
  logic [MagW-1:0]   mag;
  logic [MagW-1:0]   exit_th;
  logic [MagW-1:0]   filt_new;
  logic [DebW-1:0]   deb_inc;
  logic [DebW-1:0]   limit;
  logic              slow;
  logic              skip;
  ssc_out_t          res;

  ssc_filter u_filter (
    .mag_i    (mag),
    .value_i  (filt_q),
    .loaded_i (loaded_q),
    .alpha_i  (alpha_q),
    .value_o  (filt_new)
  );

  always_comb begin
    speed   = use_manual_q ? manual_q : in_word_q.observed_speed;
    abs16   = speed[SpeedW-1] ? (~speed + 16'd1) : speed;
    mag     = abs16[SpeedW-1] ? {MagW{1'b1}} : abs16[MagW-1:0];
    exit_th = (exit_q > enter_q) ? enter_q : exit_q;
    skip    = (in_word_q.plate_count < 3'd2) ||
              (!in_word_q.is_outpost && !in_word_q.plate_jumped);

    loaded_d = loaded_q;
    filt_d   = filt_q;
    spin_d   = spin_q;
    still_d  = still_q;
    deb_d    = deb_q;
    slow     = filt_new < static_q;
    deb_inc  = deb_q + 4'd1;
    limit    = still_q ? ExitCnt : EnterCnt;

    res.updated            = !skip;
    res.effective_speed    = speed;

    if (skip) begin
      spin_d = 1'b0;
    end else begin
      loaded_d = 1'b1;
      filt_d   = filt_new;
      if (in_word_q.is_outpost) begin
        if (slow != still_q) begin
          if (deb_inc >= limit) begin
            still_d = slow;
            deb_d   = '0;
          end else begin
            deb_d   = deb_inc;
          end
        end else begin
          deb_d = '0;
        end
        spin_d = !still_d;
      end else begin
        still_d = 1'b0;
        deb_d   = '0;
        if (spin_q) begin
          spin_d = !(filt_new < exit_th);
        end else begin
          spin_d = filt_new > enter_q;
        end
      end
    end

    res.spinning           = spin_d;
    res.outpost_still      = still_d;
    res.filtered_magnitude = filt_d;
    if (!skip && in_word_q.is_outpost && spin_d) begin
      res.filtered_magnitude = SpinMag;
      res.effective_speed    = speed[SpeedW-1] ? (~SpinPos + 16'd1) : SpinPos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      filt_q   <= '0;
      spin_q   <= 1'b0;
      still_q  <= 1'b0;
      deb_q    <= '0;
    end else if (move) begin
      loaded_q <= loaded_d;
      filt_q   <= filt_d;
      spin_q   <= spin_d;
      still_q  <= still_d;
      deb_q    <= deb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_advance) begin
      out_valid_o <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_word_o <= res;
    end
  end

endmodule
`default_nettype wire
